/* sv/tkst_pkg.sv */
// Shared types and constants for the top-k sorted insertion table.
package tkst_pkg;

	localparam int DEPTH = 16;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CAP_RESET = (DEPTH < 16) ? DEPTH : 16;

	typedef enum logic {
		ACT_INSERT = 1'b0,
		ACT_READ   = 1'b1
	} action_t;

	typedef struct packed {
		logic signed [31:0] score;
		logic [2:0]         difficulty;
		logic [7:0]         guesses;
		logic [15:0]        tag;
		logic [31:0]        stamp;
	} rec_t;

	typedef struct packed {
		logic ins;      // insert transaction this cycle
		logic live;     // slot holds a valid entry
		logic in_range; // slot below effective capacity
	} cell_ctl_t;

endpackage

/* sv/tkst_cell.sv */
// One slot of the insertion row: compare, shift from upper neighbor, or store new record.
module tkst_cell (
	input  logic              clk,
	input  tkst_pkg::cell_ctl_t ctl,
	input  tkst_pkg::rec_t    new_rec,
	input  tkst_pkg::rec_t    prev_rec,
	input  logic              prev_at,
	output logic              at,
	output tkst_pkg::rec_t    rec
);
	import tkst_pkg::*;

	rec_t rec_q;
	logic wr;

	// at: new record belongs at or above this slot
	assign at  = !ctl.live || (new_rec.score > rec_q.score);
	assign wr  = ctl.ins && ctl.in_range && (prev_at || at);
	assign rec = rec_q;

	always_ff @(posedge clk) begin
		if (wr) begin
			rec_q <= prev_at ? prev_rec : new_rec;
		end
	end

endmodule

/* sv/top_k_sorted_insert_table_core.sv */
// Top level of the top-k sorted insertion table: cell row, count, capacity and result register.
//
//   channel  signals                      direction  contents
//   in       in_valid / in_ready          input      action, record fields, read_index
//   out      out_valid / out_ready        output     accepted, position, entry_count, entry_*
//   cfg      cfg_valid / cfg_ready        input      capacity
//
// One item per cycle while not stalled: on an insert the cells compare and shift at the edge
// it is taken, the result register loads then and the result is offered the cycle after.
// in_ready drops only while a result waits and out_ready is low.
// Reset clears the entry count and sets capacity to 16; cfg_ready is always high.
module top_k_sorted_insert_table_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic         action,
	input  logic signed [31:0] score,
	input  logic [2:0]   difficulty,
	input  logic [7:0]   guesses,
	input  logic [15:0]  player_tag,
	input  logic [31:0]  timestamp,
	input  logic [3:0]   read_index,
	output logic         out_valid,
	input  logic         out_ready,
	output logic         accepted,
	output logic [3:0]   position,
	output logic [4:0]   entry_count,
	output logic         entry_valid,
	output logic signed [31:0] entry_score,
	output logic [2:0]   entry_difficulty,
	output logic [7:0]   entry_guesses,
	output logic [15:0]  entry_tag,
	output logic [31:0]  entry_time,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [4:0]   capacity
);
	import tkst_pkg::*;

	logic [CNT_W-1:0] filled_q;
	logic [CNT_W-1:0] cap_q;
	logic [CNT_W-1:0] cap_wr;
	logic [CNT_W-1:0] filled_nxt;
	logic [IDX_W-1:0] pos;
	logic [31:0]      pos_w;
	logic [31:0]      cnt_w;
	logic             acc;
	logic             in_fire;
	logic             ins_fire;
	logic             cfg_fire;
	logic             rd_valid;
	rec_t             new_rec;
	rec_t             rd_rec;
	rec_t             cell_rec [DEPTH];
	rec_t             prev_rec [DEPTH];
	logic             cell_at  [DEPTH];
	logic             prev_at  [DEPTH];
	cell_ctl_t        ctl      [DEPTH];

	logic             out_valid_q;
	logic             accepted_q;
	logic [3:0]       position_q;
	logic [4:0]       count_q;
	logic             entry_valid_q;
	rec_t             entry_q;

	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid;
	assign in_ready  = !out_valid_q || out_ready;
	assign in_fire   = in_valid && in_ready;
	assign ins_fire  = in_fire && (action_t'(action) == ACT_INSERT);

	assign new_rec = '{score: score, difficulty: difficulty, guesses: guesses,
		tag: player_tag, stamp: timestamp};

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_head
			assign prev_rec[i] = new_rec;
			assign prev_at[i]  = 1'b0;
		end else begin : g_link
			assign prev_rec[i] = cell_rec[i-1];
			assign prev_at[i]  = cell_at[i-1];
		end
		assign ctl[i] = '{ins: ins_fire,
			live: (CNT_W'(i) < filled_q),
			in_range: (CNT_W'(i) < cap_q)};
		tkst_cell u_cell (
			.clk      (clk),
			.ctl      (ctl[i]),
			.new_rec  (new_rec),
			.prev_rec (prev_rec[i]),
			.prev_at  (prev_at[i]),
			.at       (cell_at[i]),
			.rec      (cell_rec[i])
		);
	end

	// insertion point is the first slot flagged; flags are monotonic along the row
	always_comb begin
		acc = 1'b0;
		pos = '0;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (cell_at[i]) begin
				pos = IDX_W'(i);
			end
			if (cell_at[i] && (CNT_W'(i) < cap_q)) begin
				acc = 1'b1;
			end
		end
	end

	always_comb begin
		rd_rec = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (32'(read_index) == 32'(i)) begin
				rd_rec = cell_rec[i];
			end
		end
	end

	assign rd_valid = (32'(read_index) < 32'(filled_q));

	always_comb begin
		filled_nxt = filled_q;
		if (ins_fire && acc && (filled_q < cap_q)) begin
			filled_nxt = filled_q + CNT_W'(1);
		end
	end

	always_comb begin
		if (capacity == 5'd0) begin
			cap_wr = CNT_W'(1);
		end else if (32'(capacity) > 32'(DEPTH)) begin
			cap_wr = CNT_W'(DEPTH);
		end else begin
			cap_wr = CNT_W'(capacity);
		end
	end

	assign pos_w = 32'(pos);
	assign cnt_w = 32'(filled_nxt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filled_q <= '0;
			cap_q    <= CNT_W'(CAP_RESET);
		end else if (cfg_fire) begin
			cap_q <= cap_wr;
			if (filled_q > cap_wr) begin
				filled_q <= cap_wr;
			end
		end else begin
			filled_q <= filled_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			count_q <= cnt_w[4:0];
			if (action_t'(action) == ACT_INSERT) begin
				accepted_q    <= acc;
				position_q    <= acc ? pos_w[3:0] : 4'd0;
				entry_valid_q <= 1'b0;
				entry_q       <= '0;
			end else begin
				accepted_q    <= 1'b0;
				position_q    <= 4'd0;
				entry_valid_q <= rd_valid;
				entry_q       <= rd_valid ? rd_rec : '0;
			end
		end
	end

	assign out_valid        = out_valid_q;
	assign accepted         = accepted_q;
	assign position         = position_q;
	assign entry_count      = count_q;
	assign entry_valid      = entry_valid_q;
	assign entry_score      = entry_q.score;
	assign entry_difficulty = entry_q.difficulty;
	assign entry_guesses    = entry_q.guesses;
	assign entry_tag        = entry_q.tag;
	assign entry_time       = entry_q.stamp;

endmodule
